// File: rtl/rank1_cut_state_extension_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rank-1 cut state extension block
// Short forms for clocked assertions that are disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef RANK1_CUT_STATE_EXTENSION_MACROS_SVH
`define RANK1_CUT_STATE_EXTENSION_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define R1C_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define R1C_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define R1C_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/r1cut_pkg.sv
// ---------------------------------------------------------------------------
// r1cut_pkg
// Fixed field widths, stream layout and operation codes of the cut block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package r1cut_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int COUNT_W     = 8;

  typedef logic [2:0]         action_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam action_t ACT_CLEAR   = 3'd0;
  localparam action_t ACT_WR_USE  = 3'd1;
  localparam action_t ACT_WR_DEN  = 3'd2;
  localparam action_t ACT_WR_MEMB = 3'd3;
  localparam action_t ACT_EXTEND  = 3'd4;
  localparam action_t ACT_READ    = 3'd5;

endpackage

`default_nettype wire

// File: rtl/r1cut_use_ram.sv
// ---------------------------------------------------------------------------
// r1cut_use_ram
// Use table: one row per (from, to) node pair, one lane per cut, with a
// clearing pass after reset that fills every lane with the invalid code.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module r1cut_use_ram #(
  parameter int ROWS   = 1024,
  parameter int ROW_W  = 10,
  parameter int LANES  = 16,
  parameter int LANE_W = 4,
  parameter int SEL_W  = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [ROW_W-1:0]        wr_row,
  input  logic [SEL_W-1:0]        wr_lane,
  input  logic [LANE_W-1:0]       wr_data,
  input  logic                    rd_en,
  input  logic [ROW_W-1:0]        rd_row,
  output logic [LANES*LANE_W-1:0] rd_data,
  output logic                    init_done
);

  logic [LANES*LANE_W-1:0] mem [ROWS];
  logic [ROW_W-1:0]        clr_row;
  logic [ROW_W-1:0]        waddr;

  assign waddr = init_done ? wr_row : clr_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row   <= '0;
      init_done <= 1'b0;
    end else if (!init_done) begin
      clr_row <= clr_row + ROW_W'(1);
      if (clr_row == ROW_W'(ROWS - 1)) begin
        init_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (!init_done || (wr_en && wr_lane == SEL_W'(l))) begin
        mem[waddr][l*LANE_W +: LANE_W] <= init_done ? wr_data : '1;
      end
    end
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

`default_nettype wire

// File: rtl/rank1_cut_state_extension.sv
// ---------------------------------------------------------------------------
// rank1_cut_state_extension
// Fractional rank-1 cut state tracking for one route label under extension.
// ---------------------------------------------------------------------------
// Every input transaction on the s_ channel carries one operation (clear the
// label, write a use table entry, a denominator or a membership bit, extend
// the label along an arc, or read one cut) and produces exactly one result
// transaction on the m_ channel with the crossings of an extend, the number
// of active cuts, and the addressed cut on a read. Operations run one at a
// time. A use or denominator write, a clear or a spare code goes straight to
// ST_DONE, a membership write or a read first passes through ST_MEMB or
// ST_READ, and an extend through ST_WALK, where it walks the cuts one per
// cycle through the cut state memory. ST_DONE loads the result once the
// output register is free, and s_tready rises together with m_tvalid. After
// reset the use table is filled with the invalid code by a clearing pass over
// all MAX_NODES * MAX_NODES rows (1024 at the default size); s_tready stays
// low until it ends. The result sits in an output register, so when the
// receiver stalls the block may finish the next operation and then waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rank1_cut_state_extension_macros.svh"

module rank1_cut_state_extension
  import r1cut_pkg::*;
#(
  parameter int MAX_NODES  = 32,
  parameter int MAX_CUTS   = 16,
  parameter int VALUE_BITS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // action[2:0], from_node[7:3], to_node[12:8], cut_index[16:13],
  // value[20:17], member[21], zero fill[23:22]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // crossed[4:0], active_count[9:5], cut_value[13:10], cut_total[21:14],
  // cut_on[22], zero fill[23]
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CUT_W  = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1;
  localparam int ROWS   = MAX_NODES * MAX_NODES;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CNT_W  = $clog2(MAX_CUTS + 1);
  localparam int VB     = VALUE_BITS;
  localparam int ENT_W  = COUNT_W + VB;
  localparam logic [VB-1:0] INVALID_USE = '1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MEMB = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_WALK = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // Input fields.
  action_t          in_action;
  logic [4:0]       in_from;
  logic [4:0]       in_to;
  logic [3:0]       in_cut;
  logic [3:0]       in_value;
  logic             in_member;
  logic             from_ok;
  logic             to_ok;
  logic             cut_ok;
  logic [NODE_W-1:0] in_fn;
  logic [NODE_W-1:0] in_tn;
  logic [CUT_W-1:0]  in_ci;
  logic [VB-1:0]     in_v;
  logic [ROW_W-1:0]  in_row;
  logic              accept;

  assign in_action = s_tdata[2:0];
  assign in_from   = s_tdata[7:3];
  assign in_to     = s_tdata[12:8];
  assign in_cut    = s_tdata[16:13];
  assign in_value  = s_tdata[20:17];
  assign in_member = s_tdata[21];

  assign from_ok = 9'(in_from) < 9'(MAX_NODES);
  assign to_ok   = 9'(in_to) < 9'(MAX_NODES);
  assign cut_ok  = 7'(in_cut) < 7'(MAX_CUTS);
  assign in_fn   = NODE_W'(in_from);
  assign in_tn   = NODE_W'(in_to);
  assign in_ci   = CUT_W'(in_cut);
  assign in_v    = VB'(in_value);
  assign in_row  = ROW_W'(ROW_W'(in_fn) * ROW_W'(MAX_NODES) + ROW_W'(in_tn));

  // Control and latched operands.
  logic [2:0]        state;
  logic [CUT_W-1:0]  walk_idx;
  logic [CUT_W-1:0]  cidx;
  logic [NODE_W-1:0] tnode;
  logic              cidx_ok;
  logic              mem_bit;
  logic [MAX_CUTS-1:0] active;
  logic [CNT_W-1:0]  act_cnt;
  logic [CNT_W-1:0]  act_cnt_next;

  // Result fields waiting for the output register.
  logic [CNT_W-1:0]  res_crossed;
  logic [VB-1:0]     res_value;
  count_t            res_total;
  logic              res_on;
  logic              out_free;

  // Use table.
  logic                   use_ready;
  logic                   use_wr;
  logic                   use_rd;
  logic [MAX_CUTS*VB-1:0] use_row;

  assign s_tready = (state == ST_IDLE) && use_ready;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign use_wr = accept && (in_action == ACT_WR_USE) && cut_ok && from_ok && to_ok;
  assign use_rd = accept && (in_action == ACT_EXTEND) && from_ok && to_ok;

  r1cut_use_ram #(
    .ROWS   (ROWS),
    .ROW_W  (ROW_W),
    .LANES  (MAX_CUTS),
    .LANE_W (VB),
    .SEL_W  (CUT_W)
  ) u_use_ram (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (use_wr),
    .wr_row    (in_row),
    .wr_lane   (in_ci),
    .wr_data   (in_v),
    .rd_en     (use_rd),
    .rd_row    (in_row),
    .rd_data   (use_row),
    .init_done (use_ready)
  );

  // Membership memory, one row per node; a row never written reads as empty.
  logic [MAX_CUTS-1:0]  node_mem [MAX_NODES];
  logic [MAX_NODES-1:0] node_vld;
  logic [MAX_CUTS-1:0]  node_q;
  logic                 node_vld_q;
  logic [MAX_CUTS-1:0]  memb_row;
  logic [MAX_CUTS-1:0]  cut_bit;
  logic                 node_rd;

  assign node_rd  = accept && to_ok &&
                    ((in_action == ACT_WR_MEMB) || (in_action == ACT_EXTEND));
  assign memb_row = node_vld_q ? node_q : '0;
  assign cut_bit  = MAX_CUTS'(1) << cidx;

  always_ff @(posedge clk) begin
    if (node_rd) begin
      node_q <= node_mem[in_tn];
    end
    if (state == ST_MEMB) begin
      node_mem[tnode] <= mem_bit ? (memb_row | cut_bit) : (memb_row & ~cut_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_vld   <= '0;
      node_vld_q <= 1'b0;
    end else begin
      if (node_rd) begin
        node_vld_q <= node_vld[in_tn];
      end
      if (state == ST_MEMB) begin
        node_vld[tnode] <= 1'b1;
      end
    end
  end

  // Per-cut state memory {count, state} and denominator memory, both read
  // every cycle at the cut the next cycle will work on.
  logic [ENT_W-1:0]    cut_mem [MAX_CUTS];
  logic [MAX_CUTS-1:0] cut_vld;
  logic [ENT_W-1:0]    cut_q;
  logic                cut_vld_q;
  logic [VB-1:0]       den_mem [MAX_CUTS];
  logic [VB-1:0]       den_q;
  logic [CUT_W-1:0]    rd_addr;
  logic                den_wr;
  logic                walk_last;
  logic [VB-1:0]       u;
  logic [VB-1:0]       st;
  count_t              cnt;
  logic [VB:0]         sum;
  logic [VB:0]         diff;
  logic                was_act;
  logic                new_act;
  logic [VB-1:0]       new_st;
  count_t              new_cnt;
  logic                bump;

  assign walk_last = (walk_idx == CUT_W'(MAX_CUTS - 1));
  assign den_wr    = accept && (in_action == ACT_WR_DEN) && cut_ok;

  always_comb begin
    if (state == ST_WALK) begin
      rd_addr = walk_last ? '0 : walk_idx + CUT_W'(1);
    end else if (in_action == ACT_READ && cut_ok) begin
      rd_addr = in_ci;
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    cut_q <= cut_mem[rd_addr];
    den_q <= den_mem[rd_addr];
    if (den_wr) begin
      den_mem[in_ci] <= (in_v == '0) ? VB'(1) : in_v;
    end
    if (state == ST_WALK) begin
      cut_mem[walk_idx] <= {new_cnt, new_st};
    end
  end

  // One cut of an extend: the active path and the activation of an
  // untouched member cut are folded into a single step.
  always_comb begin
    u       = use_row[walk_idx*VB +: VB];
    st      = cut_vld_q ? cut_q[VB-1:0] : '0;
    cnt     = cut_vld_q ? cut_q[ENT_W-1:VB] : '0;
    was_act = active[walk_idx];
    sum     = {1'b0, st} + {1'b0, u};
    diff    = sum - {1'b0, den_q};
    new_act = was_act;
    new_st  = st;
    bump    = 1'b0;
    if (was_act) begin
      if (u == INVALID_USE) begin
        new_act = 1'b0;
        new_st  = '0;
      end else if (u != '0) begin
        if (sum == {1'b0, den_q}) begin
          bump    = 1'b1;
          new_act = 1'b0;
          new_st  = '0;
        end else if (sum < {1'b0, den_q}) begin
          new_st = sum[VB-1:0];
        end else begin
          bump   = 1'b1;
          new_st = diff[VB] ? INVALID_USE : diff[VB-1:0];
        end
      end else if (memb_row[walk_idx]) begin
        new_st = u;
      end
    end else if (memb_row[walk_idx] && u != INVALID_USE) begin
      new_act = 1'b1;
      new_st  = u;
    end
    new_cnt = (bump && cnt != '1) ? cnt + count_t'(1) : cnt;
    if (new_act && !was_act) begin
      act_cnt_next = act_cnt + CNT_W'(1);
    end else if (was_act && !new_act) begin
      act_cnt_next = act_cnt - CNT_W'(1);
    end else begin
      act_cnt_next = act_cnt;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      walk_idx  <= '0;
      active    <= '0;
      act_cnt   <= '0;
      cut_vld   <= '0;
      cut_vld_q <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      cut_vld_q <= cut_vld[rd_addr];
      // In ST_DONE the valid flag is set again below when the register frees.
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res_crossed <= '0;
            res_value   <= '0;
            res_total   <= '0;
            res_on      <= 1'b0;
            cidx        <= in_ci;
            cidx_ok     <= cut_ok;
            tnode       <= in_tn;
            mem_bit     <= in_member;
            walk_idx    <= '0;
            case (in_action)
              ACT_CLEAR: begin
                active  <= '0;
                act_cnt <= '0;
                cut_vld <= '0;
                state   <= ST_DONE;
              end
              ACT_WR_MEMB: begin
                state <= (cut_ok && to_ok) ? ST_MEMB : ST_DONE;
              end
              ACT_EXTEND: begin
                state <= (from_ok && to_ok) ? ST_WALK : ST_DONE;
              end
              ACT_READ: begin
                state <= ST_READ;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_MEMB: begin
          state <= ST_DONE;
        end
        ST_READ: begin
          if (cidx_ok) begin
            res_value <= cut_vld_q ? cut_q[VB-1:0] : '0;
            res_total <= cut_vld_q ? cut_q[ENT_W-1:VB] : '0;
            res_on    <= active[cidx];
          end
          state <= ST_DONE;
        end
        ST_WALK: begin
          active[walk_idx]  <= new_act;
          act_cnt           <= act_cnt_next;
          cut_vld[walk_idx] <= 1'b1;
          if (bump) begin
            res_crossed <= res_crossed + CNT_W'(1);
          end
          walk_idx <= walk_last ? '0 : walk_idx + CUT_W'(1);
          if (walk_last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {1'b0, res_on, res_total, 4'(res_value), 5'(act_cnt), 5'(res_crossed)};
    end
  end

  // Checks on the sequencer and the active bookkeeping.
  `R1C_ASSERT_ALWAYS(a_active_count, clk, rst, 32'($countones(active)) == 32'(act_cnt), "active count out of step with active set")
  `R1C_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready, "new transaction taken while one is in progress")
  `R1C_ASSERT_IMPLIES(a_walk_range, clk, rst, state == ST_WALK, 32'(walk_idx) < 32'(MAX_CUTS), "cut walk beyond last cut")
  `R1C_ASSERT_NEXT(a_done_holds, clk, rst, state == ST_DONE && m_tvalid && !m_tready, state == ST_DONE, "result dropped while output is stalled")

endmodule

`default_nettype wire
